// File: src/iradx_pkg.sv
// shared constants, job type and digit-to-ascii mapping for the radix converter
`default_nettype none

package iradx_pkg;

   // value width in use, port keeps the full 64 bits
   localparam int VALUE_WIDTH = 64;
   localparam int IN_W        = 64;

   // division works one byte of dividend per cycle
   localparam int CHUNK_W = 8;
   localparam int CHUNKS  = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
   localparam int WORK_W  = CHUNKS * CHUNK_W;
   localparam int STEP_W  = $clog2(CHUNKS + 1);

   // radix 2 gives the longest run
   localparam int MAX_DIGITS = VALUE_WIDTH;
   localparam int DIG_W      = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W      = $clog2(MAX_DIGITS);

   // job queue, depth a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] OP_UNSIGNED_UPPER = 2'd0;
   localparam logic [1:0] OP_UNSIGNED_LOWER = 2'd1;
   localparam logic [1:0] OP_SIGNED         = 2'd2;

   localparam logic [5:0] RADIX_MIN = 6'd2;
   localparam logic [5:0] RADIX_MAX = 6'd36;

   localparam logic [5:0] DEC_LIMIT     = 6'd10;
   localparam logic [6:0] CH_ZERO       = 7'h30;
   localparam logic [6:0] CH_UPPER_BASE = 7'h37;
   localparam logic [6:0] CH_LOWER_BASE = 7'h57;

   typedef struct packed {
      logic [WORK_W-1:0] mag;
      logic [5:0]        radix;
      logic              lower;
   } iradx_job_type;

   function automatic logic [6:0] digit_to_char(input logic [5:0] d, input logic lower);
      logic [6:0] base;
      if (d < DEC_LIMIT) begin
         base = CH_ZERO;
      end else if (lower) begin
         base = CH_LOWER_BASE;
      end else begin
         base = CH_UPPER_BASE;
      end
      return 7'(base + 7'(d));
   endfunction

endpackage

`default_nettype wire

// File: src/iradx_front.sv
// front end: takes request items, clamps the radix and forms the magnitude
`default_nettype none

module iradx_front
   import iradx_pkg::*;
(
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic [1:0]      req_opcode,
   input  wire logic [5:0]      req_radix,
   input  wire logic [IN_W-1:0] req_value,
   input  wire logic            queue_full,
   output logic                 push,
   output iradx_job_type        push_job
);

   logic [VALUE_WIDTH-1:0] v;
   logic [VALUE_WIDTH-1:0] v_neg;
   logic                   is_signed;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      v         = req_value[VALUE_WIDTH-1:0];
      v_neg     = VALUE_WIDTH'(~v + 1'b1);
      is_signed = (req_opcode == OP_SIGNED);

      // two's-complement negate also covers the most negative value
      if (is_signed && v[VALUE_WIDTH-1]) begin
         push_job.mag = WORK_W'(v_neg);
      end else begin
         push_job.mag = WORK_W'(v);
      end

      if (req_radix < RADIX_MIN) begin
         push_job.radix = RADIX_MIN;
      end else if (req_radix > RADIX_MAX) begin
         push_job.radix = RADIX_MAX;
      end else begin
         push_job.radix = req_radix;
      end

      push_job.lower = is_signed || (req_opcode == OP_UNSIGNED_LOWER);
   end

endmodule

`default_nettype wire

// File: src/iradx_queue.sv
// short job queue between front end and conversion engine
`default_nettype none

module iradx_queue
   import iradx_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  iradx_job_type      push_job,
   output logic               full,
   input  wire logic          pop,
   output logic               head_valid,
   output iradx_job_type      head_job
);

   iradx_job_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push   ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (do_pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// File: src/iradx_back.sv
// conversion engine: byte-serial division, digit store and msd-first emission
`default_nettype none

module iradx_back
   import iradx_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     job_valid,
   input  iradx_job_type job,
   output logic          pop,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output logic [6:0]    rsp_digit_char,
   output logic          rsp_last_digit
);

   typedef enum logic [4:0] {
      B_IDLE = 5'b00001,
      B_LOAD = 5'b00010,
      B_DIV  = 5'b00100,
      B_TURN = 5'b01000,
      B_EMIT = 5'b10000
   } back_state_type;

   back_state_type     state_ff, state_in;
   logic [WORK_W-1:0]  dv_ff, dv_in;
   logic [5:0]         rem_ff, rem_in;
   logic [5:0]         radix_ff, radix_in;
   logic               lower_ff, lower_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic [DIG_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [5:0]         mem_q_ff;
   logic [5:0]         digit_mem [MAX_DIGITS];
   logic               wr_en;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [6:0]         rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               out_free;

   logic [7:0]         qbyte;
   logic [5:0]         rem_nx;
   logic [STEP_W-1:0]  nch;
   logic [STEP_W-1:0]  shamt;

   // eight restoring steps on one dividend byte
   function automatic logic [13:0] div_byte(input logic [5:0] r, input logic [7:0] b,
                                            input logic [5:0] d);
      logic [6:0] t;
      logic [5:0] rr;
      logic [7:0] q;
      rr = r;
      q  = '0;
      for (int i = 7; i >= 0; i--) begin
         t = {rr, b[i]};
         if (t >= {1'b0, d}) begin
            rr   = 6'(t - {1'b0, d});
            q[i] = 1'b1;
         end else begin
            rr = t[5:0];
         end
      end
      return {q, rr};
   endfunction

   assign {qbyte, rem_nx} = div_byte(rem_ff, dv_ff[WORK_W-1 -: CHUNK_W], radix_ff);

   // number of significant bytes, at least one so zero still yields a digit
   always_comb begin
      nch = STEP_W'(1);
      for (int i = 0; i < CHUNKS; i++) begin
         if (|dv_ff[i*CHUNK_W +: CHUNK_W]) begin
            nch = STEP_W'(i + 1);
         end
      end
      shamt = STEP_W'(STEP_W'(CHUNKS) - nch);
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      dv_in        = dv_ff;
      rem_in       = rem_ff;
      radix_in     = radix_ff;
      lower_in     = lower_ff;
      steps_in     = steps_ff;
      cnt_in       = cnt_ff;
      rd_ptr_in    = rd_ptr_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               pop      = 1'b1;
               dv_in    = job.mag;
               radix_in = job.radix;
               lower_in = job.lower;
               cnt_in   = '0;
               state_in = B_LOAD;
            end
         end
         B_LOAD: begin
            dv_in    = dv_ff << (32'(shamt) * CHUNK_W);
            steps_in = nch;
            rem_in   = '0;
            state_in = B_DIV;
         end
         B_DIV: begin
            dv_in    = (dv_ff << CHUNK_W) | WORK_W'(qbyte);
            rem_in   = rem_nx;
            steps_in = STEP_W'(steps_ff - 1'b1);
            if (steps_ff == STEP_W'(1)) begin
               wr_en  = 1'b1;
               cnt_in = DIG_W'(cnt_ff + 1'b1);
               if (dv_in != '0) begin
                  state_in = B_LOAD;
               end else begin
                  state_in = B_TURN;
               end
            end
         end
         B_TURN: begin
            rd_ptr_in = IDX_W'(cnt_ff - 1'b1);
            state_in  = B_EMIT;
         end
         B_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_to_char(mem_q_ff, lower_ff);
               rsp_last_in  = (rd_ptr_ff == '0);
               if (rd_ptr_ff == '0) begin
                  state_in = B_IDLE;
               end else begin
                  rd_ptr_in = IDX_W'(rd_ptr_ff - 1'b1);
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dv_ff       <= dv_in;
      rem_ff      <= rem_in;
      radix_ff    <= radix_in;
      lower_ff    <= lower_in;
      steps_ff    <= steps_in;
      cnt_ff      <= cnt_in;
      rd_ptr_ff   <= rd_ptr_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // digit store, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_mem[cnt_ff[IDX_W-1:0]] <= rem_nx;
      end
      mem_q_ff <= digit_mem[rd_ptr_in];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last_digit = rsp_last_ff;

endmodule

`default_nettype wire

// File: src/integer_to_radix_digits.sv
// top level of the integer to ascii radix digit converter
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_opcode[1:0] req_radix[5:0] req_value[63:0]
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_digit_char[6:0] rsp_last_digit
//
// an item is popped, then each digit takes a load step plus one division step per
//   significant byte of the remaining value (byte-serial divider), then a
//   turnaround step, then the digits are emitted one by one from the digit store
// reset is synchronous and active high; it empties the queue and idles the engine
// a two-deep queue lets requests be taken while the engine works or rsp stalls
// rsp stall holds the output register and pauses emission; the next item can
//   already be divided while the last digit of the previous one waits
`default_nettype none

module integer_to_radix_digits
   import iradx_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic [1:0]      req_opcode,
   input  wire logic [5:0]      req_radix,
   input  wire logic [IN_W-1:0] req_value,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output logic [6:0]           rsp_digit_char,
   output logic                 rsp_last_digit
);

   // front to queue
   logic          push;
   iradx_job_type push_job;
   logic          queue_full;

   // queue to engine
   logic          head_valid;
   iradx_job_type head_job;
   logic          pop;

   // classify: clamp radix, signed magnitude, letter case
   iradx_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .req_radix  (req_radix),
      .req_value  (req_value),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   // decouples request intake from the long conversion
   iradx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // divide into the digit store lsd first, then replay msd first
   iradx_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (head_valid),
      .job            (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

endmodule

`default_nettype wire

// File: src/iradx_checker.sv
// port-level checks for the radix converter, bound to the top level
`default_nettype none

module iradx_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [6:0]  rsp_digit_char,
   input wire logic        rsp_last_digit
);

   // items taken in whose last digit has not gone out
   logic [3:0] open_ff, open_in;
   logic       req_take;
   logic       rsp_done;

   assign req_take = req_valid && !req_stall;
   assign rsp_done = rsp_valid && !rsp_stall && rsp_last_digit;

   always_comb begin
      open_in = open_ff;
      if (req_take && !rsp_done) begin
         open_in = 4'(open_ff + 1'b1);
      end else if (rsp_done && !req_take) begin
         open_in = 4'(open_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("rsp valid right after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digit_char)
                                 && $stable(rsp_last_digit))
      else $error("stalled rsp item changed");

   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 4'd0)
      else $error("rsp item with no request item open");

   a_digit_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_char >= 7'h30 && rsp_digit_char <= 7'h39)
                 || (rsp_digit_char >= 7'h41 && rsp_digit_char <= 7'h5a)
                 || (rsp_digit_char >= 7'h61 && rsp_digit_char <= 7'h7a))
      else $error("rsp digit is not a digit or letter");

endmodule

bind integer_to_radix_digits iradx_checker u_iradx_checker (.*);

`default_nettype wire
